// File: rtl/gsa_pkg.sv
package gsa_pkg;

   // Store geometry
   localparam int MAX_ENTRIES  = 1024;
   localparam int ADDR_W       = $clog2(MAX_ENTRIES);
   localparam int COUNT_W      = $clog2(MAX_ENTRIES + 1);

   // Field widths
   localparam int CHAR_W       = 16;
   localparam int SUBSET_W     = 9;
   localparam int GLYPH_W      = 8;

   // Subset layout
   localparam int SUBSET_SIZE  = 255;
   localparam int LATIN1_LIMIT = 256;
   localparam int LATIN1_SUBSET = 1;
   localparam int FIRST_SUBSET = 2;

   typedef logic [CHAR_W-1:0]   char_type;
   typedef logic [SUBSET_W-1:0] subset_type;
   typedef logic [GLYPH_W-1:0]  glyph_type;
   typedef logic [COUNT_W-1:0]  count_type;
   typedef logic [ADDR_W-1:0]   addr_type;

   // Position of a store entry within the subset layout
   typedef struct packed {
      subset_type subset;
      glyph_type  glyph;
   } pos_type;

   localparam pos_type FIRST_POS = '{subset: SUBSET_W'(FIRST_SUBSET), glyph: '0};

   // Step to the position of the following entry
   function automatic pos_type next_pos(input pos_type p);
      pos_type r;
      if (p.glyph == GLYPH_W'(SUBSET_SIZE - 1)) begin
         r.subset = p.subset + SUBSET_W'(1);
         r.glyph  = '0;
      end else begin
         r.subset = p.subset;
         r.glyph  = p.glyph + GLYPH_W'(1);
      end
      return r;
   endfunction

endpackage

// File: rtl/gsa_if.sv
interface gsa_req_if import gsa_pkg::*; ();
   logic     valid;
   logic     ready;
   char_type char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface gsa_rsp_if import gsa_pkg::*; ();
   logic       valid;
   logic       ready;
   subset_type subset_number;
   glyph_type  code_in_subset;
   logic       newly_added;
   logic       store_full;

   modport source (output valid, output subset_number, output code_in_subset,
                   output newly_added, output store_full, input ready);
   modport sink   (input valid, input subset_number, input code_in_subset,
                   input newly_added, input store_full, output ready);
endinterface

// File: rtl/gsa_ram.sv
module gsa_ram #(
   parameter int WIDTH = 16,
   parameter int DEPTH = 1024
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// File: rtl/glyph_subset_allocator.sv
// Channel   Modport  Direction  Payload
// req_chan  sink     in         char_code (16)
// rsp_chan  source   out        subset_number (9), code_in_subset (8),
//                               newly_added (1), store_full (1)
//
// A code below 256 is answered in the cycle after accept. Any other code scans
// the character store, one entry read per cycle through the store RAM port; a
// compare stage after the RAM register finds a hit, a miss once all are compared.
// Reset clears state, entry count and valid flags; the store needs no clearing.
// The result waits in an output register; a new transaction is taken once
// the scan is done and that register is empty or being emptied.
module glyph_subset_allocator import gsa_pkg::*; (
   input  logic     clock,
   input  logic     reset,
   gsa_req_if.sink  req_chan,
   gsa_rsp_if.source rsp_chan
);

   typedef enum logic [0:0] {
      ST_IDLE,
      ST_SCAN
   } state_type;

   state_type  state_ff;
   char_type   code_ff;

   // Fill level of the store and the position the next insert lands on
   count_type  count_ff;
   pos_type    count_pos_ff;

   // Scan pointers: the entry being read and the entry being compared
   count_type  issue_idx_ff;
   pos_type    issue_pos_ff;
   logic       cmp_valid_ff;
   pos_type    cmp_pos_ff;

   // Output register
   logic       rsp_valid_ff;
   subset_type rsp_subset_ff;
   glyph_type  rsp_glyph_ff;
   logic       rsp_new_ff;
   logic       rsp_full_ff;

   logic       accept;
   logic       issue;
   logic       hit;
   logic       scan_done;
   logic       insert;
   logic       rsp_load;
   char_type   rd_data;

   assign req_chan.ready = !reset && (state_ff == ST_IDLE) &&
                           (!rsp_valid_ff || rsp_chan.ready);
   assign accept         = req_chan.valid && req_chan.ready;

   // Issue one read per cycle until every stored entry has been fetched
   assign issue     = (state_ff == ST_SCAN) && (issue_idx_ff != count_ff);
   assign hit       = (state_ff == ST_SCAN) && cmp_valid_ff && (rd_data == code_ff);
   assign scan_done = (state_ff == ST_SCAN) && !issue && !hit;
   assign insert    = scan_done && (count_ff != COUNT_W'(MAX_ENTRIES));

   // Load the output register whenever a transaction finishes this cycle
   assign rsp_load  = (accept && (req_chan.char_code < CHAR_W'(LATIN1_LIMIT))) ||
                      hit || scan_done;

   gsa_ram #(
      .WIDTH (CHAR_W),
      .DEPTH (MAX_ENTRIES)
   ) u_store (
      .clock   (clock),
      .wr_en   (insert),
      .wr_addr (count_ff[ADDR_W-1:0]),
      .wr_data (code_ff),
      .rd_addr (issue_idx_ff[ADDR_W-1:0]),
      .rd_data (rd_data)
   );

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         count_ff     <= '0;
         count_pos_ff <= FIRST_POS;
         cmp_valid_ff <= 1'b0;
         rsp_valid_ff <= 1'b0;
      end else begin
         // Hold a fresh result; otherwise drop the result once the sink takes it
         if (rsp_load) begin
            rsp_valid_ff <= 1'b1;
         end else if (rsp_valid_ff && rsp_chan.ready) begin
            rsp_valid_ff <= 1'b0;
         end

         unique case (state_ff)
            ST_IDLE: begin
               if (accept) begin
                  code_ff <= req_chan.char_code;
                  if (req_chan.char_code < CHAR_W'(LATIN1_LIMIT)) begin
                     // Latin1 bypasses the store entirely
                     rsp_subset_ff <= SUBSET_W'(LATIN1_SUBSET);
                     rsp_glyph_ff  <= req_chan.char_code[GLYPH_W-1:0];
                     rsp_new_ff    <= 1'b0;
                     rsp_full_ff   <= 1'b0;
                  end else begin
                     issue_idx_ff <= '0;
                     issue_pos_ff <= FIRST_POS;
                     cmp_valid_ff <= 1'b0;
                     state_ff     <= ST_SCAN;
                  end
               end
            end

            ST_SCAN: begin
               // Advance the read pointer; the compare stage trails it by one entry
               cmp_valid_ff <= issue;
               cmp_pos_ff   <= issue_pos_ff;
               if (issue) begin
                  issue_idx_ff <= issue_idx_ff + COUNT_W'(1);
                  issue_pos_ff <= next_pos(issue_pos_ff);
               end

               if (hit) begin
                  rsp_subset_ff <= cmp_pos_ff.subset;
                  rsp_glyph_ff  <= cmp_pos_ff.glyph;
                  rsp_new_ff    <= 1'b0;
                  rsp_full_ff   <= 1'b0;
                  state_ff      <= ST_IDLE;
               end else if (scan_done) begin
                  state_ff     <= ST_IDLE;
                  if (insert) begin
                     // Append at the current fill level
                     rsp_subset_ff <= count_pos_ff.subset;
                     rsp_glyph_ff  <= count_pos_ff.glyph;
                     rsp_new_ff    <= 1'b1;
                     rsp_full_ff   <= 1'b0;
                     count_ff      <= count_ff + COUNT_W'(1);
                     count_pos_ff  <= next_pos(count_pos_ff);
                  end else begin
                     // Store full: report and keep the state
                     rsp_subset_ff <= '0;
                     rsp_glyph_ff  <= '0;
                     rsp_new_ff    <= 1'b0;
                     rsp_full_ff   <= 1'b1;
                  end
               end
            end

            default: begin
               state_ff <= ST_IDLE;
            end
         endcase
      end
   end

   assign rsp_chan.valid          = rsp_valid_ff;
   assign rsp_chan.subset_number  = rsp_subset_ff;
   assign rsp_chan.code_in_subset = rsp_glyph_ff;
   assign rsp_chan.newly_added    = rsp_new_ff;
   assign rsp_chan.store_full     = rsp_full_ff;

endmodule

// File: rtl/gsa_checker.sv
module gsa_checker import gsa_pkg::*; (
   input logic       clock,
   input logic       reset,
   input logic       req_valid,
   input logic       req_ready,
   input char_type   req_char_code,
   input logic       rsp_valid,
   input logic       rsp_ready,
   input subset_type rsp_subset_number,
   input glyph_type  rsp_code_in_subset,
   input logic       rsp_newly_added,
   input logic       rsp_store_full
);

   // A latin1 transaction returns its own code in subset 1 on the next cycle
   assert property (@(posedge clock) disable iff (reset)
      (req_valid && req_ready && req_char_code < CHAR_W'(LATIN1_LIMIT)) |=>
      (rsp_valid && rsp_subset_number == SUBSET_W'(LATIN1_SUBSET) &&
       rsp_code_in_subset == $past(req_char_code[GLYPH_W-1:0]) &&
       !rsp_newly_added && !rsp_store_full))
      else $error("latin1 result wrong or late");

   // A full-store result carries no placement
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_store_full) |->
      (rsp_subset_number == '0 && rsp_code_in_subset == '0 && !rsp_newly_added))
      else $error("store full result carries a placement");

   // A fresh insert lands in a store subset
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && rsp_newly_added) |->
      (rsp_subset_number >= SUBSET_W'(FIRST_SUBSET) && !rsp_store_full))
      else $error("insert result outside the store subsets");

   // A stalled result holds
   assert property (@(posedge clock) disable iff (reset)
      (rsp_valid && !rsp_ready) |=>
      (rsp_valid && $stable(rsp_subset_number) && $stable(rsp_code_in_subset) &&
       $stable(rsp_newly_added) && $stable(rsp_store_full)))
      else $error("stalled result changed");

endmodule

bind glyph_subset_allocator gsa_checker u_gsa_checker (
   .clock              (clock),
   .reset              (reset),
   .req_valid          (req_chan.valid),
   .req_ready          (req_chan.ready),
   .req_char_code      (req_chan.char_code),
   .rsp_valid          (rsp_chan.valid),
   .rsp_ready          (rsp_chan.ready),
   .rsp_subset_number  (rsp_chan.subset_number),
   .rsp_code_in_subset (rsp_chan.code_in_subset),
   .rsp_newly_added    (rsp_chan.newly_added),
   .rsp_store_full     (rsp_chan.store_full)
);

// File: sim/glyph_subset_allocator_checker.sv
module glyph_subset_allocator_checker import gsa_pkg::*; (
   input  logic clock,
   input  logic reset,
   gsa_req_if   req_chan,
   gsa_rsp_if   rsp_chan,
   output int   fail_count,
   output int   pending_count
);
   timeunit 1ns;
   timeprecision 1ps;

   typedef struct packed {
      subset_type subset_number;
      glyph_type  code_in_subset;
      logic       newly_added;
      logic       store_full;
   } mapping_type;

   char_type    char_store [MAX_ENTRIES];
   int          entry_total;
   mapping_type mapping_q [$];

   initial begin
      fail_count    = 0;
      pending_count = 0;
      entry_total   = 0;
   end

   // Map one code and update the private copy of the store.
   function automatic mapping_type map_char(input char_type code);
      mapping_type m;
      int          slot;
      m    = '0;
      slot = -1;
      if (code < LATIN1_LIMIT) begin
         m.subset_number  = SUBSET_W'(LATIN1_SUBSET);
         m.code_in_subset = code[GLYPH_W-1:0];
         return m;
      end
      for (int k = 0; k < entry_total; k++) begin
         if (slot < 0 && char_store[k] == code) begin
            slot = k;
         end
      end
      if (slot < 0) begin
         if (entry_total >= MAX_ENTRIES) begin
            m.store_full = 1'b1;
            return m;
         end
         slot             = entry_total;
         char_store[slot] = code;
         entry_total      = entry_total + 1;
         m.newly_added    = 1'b1;
      end
      m.subset_number  = SUBSET_W'(FIRST_SUBSET + slot / SUBSET_SIZE);
      m.code_in_subset = GLYPH_W'(slot % SUBSET_SIZE);
      return m;
   endfunction

   task automatic report_mismatch(input string msg);
      $display("mismatch at %0t: %s", $time, msg);
      fail_count = fail_count + 1;
   endtask

   task automatic check_field(input string name, input logic [15:0] got,
                              input logic [15:0] want);
      if (got !== want) begin
         report_mismatch($sformatf("%s got %0h, expected %0h", name, got, want));
      end
   endtask

   always @(posedge clock) begin
      mapping_type want;
      if (reset) begin
         entry_total = 0;
         mapping_q.delete();
      end else begin
         if (req_chan.valid && req_chan.ready) begin
            mapping_q = {mapping_q, map_char(req_chan.char_code)};
         end
         if (rsp_chan.valid && rsp_chan.ready) begin
            if (mapping_q.size() == 0) begin
               report_mismatch("result with no transaction waiting");
            end else begin
               want = mapping_q.pop_front();
               check_field("subset_number", 16'(rsp_chan.subset_number),
                           16'(want.subset_number));
               check_field("code_in_subset", 16'(rsp_chan.code_in_subset),
                           16'(want.code_in_subset));
               check_field("newly_added", 16'(rsp_chan.newly_added),
                           16'(want.newly_added));
               check_field("store_full", 16'(rsp_chan.store_full),
                           16'(want.store_full));
            end
         end
      end
      pending_count = mapping_q.size();
   end

endmodule

// File: sim/glyph_subset_allocator_tb.sv
module glyph_subset_allocator_tb;
   timeunit 1ns;
   timeprecision 1ps;
   import gsa_pkg::*;

   // A miss on a full store scans every entry before answering; allow a
   // long margin on top of that for receiver stalls.
   localparam int WATCHDOG_LIMIT = 8000;
   localparam int DRAIN_CYCLES   = 1100;
   localparam int IDLE_PCT       = 17;

   logic clock;
   logic reset;
   bit   calm;
   int   fail_count;
   int   pending_count;
   int   quiet_cycles;

   // Codes the store will hold, in insertion order, plus a lookup set.
   char_type stored_codes [$];
   bit       known_codes [char_type];

   gsa_req_if req_chan ();
   gsa_rsp_if rsp_chan ();

   glyph_subset_allocator u_dut (
      .clock    (clock),
      .reset    (reset),
      .req_chan (req_chan),
      .rsp_chan (rsp_chan)
   );

   glyph_subset_allocator_checker u_checker (
      .clock         (clock),
      .reset         (reset),
      .req_chan      (req_chan),
      .rsp_chan      (rsp_chan),
      .fail_count    (fail_count),
      .pending_count (pending_count)
   );

   always begin
      clock = 1'b0;
      #4;
      clock = 1'b1;
      #4;
   end

   // Stall the result side at random, except in the calm stretch.
   always @(negedge clock) begin
      if (reset) begin
         rsp_chan.ready <= 1'b0;
      end else begin
         rsp_chan.ready <= calm || ($urandom_range(99) >= IDLE_PCT);
      end
   end

   // Abort when neither channel moves a transaction for too long.
   always @(posedge clock) begin
      if (reset || (req_chan.valid && req_chan.ready) ||
          (rsp_chan.valid && rsp_chan.ready)) begin
         quiet_cycles <= 0;
      end else begin
         quiet_cycles <= quiet_cycles + 1;
         if (quiet_cycles >= WATCHDOG_LIMIT) begin
            $display("status: fail");
            $finish;
         end
      end
   end

   // Pick a code of 256 or above that the store does not hold.
   function automatic char_type fresh_code();
      char_type code;
      do begin
         code = char_type'($urandom_range(16'hFFFF, LATIN1_LIMIT));
      end while (known_codes.exists(code));
      return code;
   endfunction

   // Send one code; called and returning at a falling edge. Valid is only
   // lowered on an idle cycle, so it never drops and rises in one step.
   task automatic send_char(input char_type code);
      if (code >= LATIN1_LIMIT && !known_codes.exists(code) &&
          stored_codes.size() < MAX_ENTRIES) begin
         known_codes[code] = 1'b1;
         stored_codes = {stored_codes, code};
      end
      if (!calm) begin
         while ($urandom_range(99) < IDLE_PCT) begin
            req_chan.valid <= 1'b0;
            @(negedge clock);
         end
      end
      req_chan.valid     <= 1'b1;
      req_chan.char_code <= code;
      do @(posedge clock); while (!req_chan.ready);
      @(negedge clock);
   endtask

   // Mix latin1 codes, lookups of stored codes and fresh codes.
   task automatic send_random(input int latin1_pct, input int hit_pct);
      int roll;
      roll = $urandom_range(99);
      if (roll < latin1_pct) begin
         send_char(char_type'($urandom_range(LATIN1_LIMIT - 1)));
      end else if (roll < latin1_pct + hit_pct && stored_codes.size() > 0) begin
         send_char(stored_codes[$urandom_range(stored_codes.size() - 1)]);
      end else begin
         send_char(fresh_code());
      end
   endtask

   // Hold off the sender until every outstanding result is back.
   task automatic drain_results();
      req_chan.valid <= 1'b0;
      @(negedge clock);
      while (pending_count != 0) @(negedge clock);
   endtask

   initial begin
      reset              = 1'b1;
      calm               = 1'b0;
      quiet_cycles       = 0;
      req_chan.valid     = 1'b0;
      req_chan.char_code = '0;
      rsp_chan.ready     = 1'b0;
      repeat (4) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed: latin1 bounds, first inserts, bit extremes, repeat hits.
      send_char(16'h0000);
      send_char(16'h00FF);
      send_char(16'h0080);
      send_char(16'h0100);
      send_char(16'hFFFF);
      send_char(16'h8000);
      send_char(16'h7FFF);
      send_char(16'h5555);
      send_char(16'hAAAA);
      send_char(16'h0100);
      send_char(16'hFFFF);
      send_char(16'h5555);
      send_char(16'h00AA);

      // Let the block go fully idle once with results outstanding.
      drain_results();

      // Random with a small store; run a stretch with no idling on either side.
      for (int i = 0; i < 250; i++) begin
         calm = (i >= 100 && i < 180);
         send_random(15, 45);
      end
      calm = 1'b0;
      drain_results();

      // Grow the store past the first subset boundary.
      while (stored_codes.size() < SUBSET_SIZE + 40) begin
         send_random(5, 10);
      end

      // First and last entries and both sides of the subset edge.
      send_char(stored_codes[0]);
      send_char(stored_codes[SUBSET_SIZE - 1]);
      send_char(stored_codes[SUBSET_SIZE]);
      send_char(stored_codes[stored_codes.size() - 1]);
      for (int i = 0; i < 100; i++) begin
         send_random(30, 40);
      end

      // Drop valid, wait out the results, then watch for strays.
      req_chan.valid <= 1'b0;
      while (pending_count != 0) @(negedge clock);
      repeat (DRAIN_CYCLES) @(negedge clock);

      if (fail_count == 0 && pending_count == 0) begin
         $display("status: pass");
      end else begin
         $display("status: fail");
      end
      $finish;
   end

endmodule
